/* sv/uri_percent_encode_fixup_assert.svh */
// Assertion macros for the URI percent-encoding fixup block.
// Expects clk and rst_n in the scope of each use.
`ifndef URI_PERCENT_ENCODE_FIXUP_ASSERT_SVH
`define URI_PERCENT_ENCODE_FIXUP_ASSERT_SVH

`ifndef SYNTHESIS
`define URIPE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uripe assertion failed");
`define URIPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uripe assertion failed");
`else
`define URIPE_ASSERT_NOW(lbl, ante, cons)
`define URIPE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* sv/uripe_pkg.sv */
// Package for the URI percent-encoding fixup block: payload types,
// character constants and class-test functions. No dependencies.
`timescale 1ns / 1ps

package uripe_pkg;

  typedef struct packed {
    logic       operation;
    logic [7:0] char_byte;
    logic       is_final;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       string_end;
  } out_t;

  localparam logic       OP_SCAN   = 1'b0;
  localparam logic       OP_ENCODE = 1'b1;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam int         MAX_RES   = 4;

  function automatic logic is_alnum(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
  endfunction

  // unreserved plus sub-delimiters
  function automatic logic is_plain(input logic [7:0] b);
    return is_alnum(b) || (b inside {"-", ".", "_", "~", "!", "$", "&", "'", "(", ")",
                                     "*", "+", ",", ";", "="});
  endfunction

  function automatic logic is_scheme(input logic [7:0] b);
    return is_alnum(b) || (b inside {"+", "-", "."});
  endfunction

  function automatic logic is_auth_end(input logic [7:0] b);
    return b inside {"/", "?", "#"};
  endfunction

  function automatic logic auth_extra(input logic [7:0] b, input logic pct_ok);
    return (b inside {":", "[", "]", "@"}) || (pct_ok && b == CH_PCT);
  endfunction

  function automatic logic path_extra(input logic [7:0] b, input logic brk,
                                      input logic pct_ok);
    return (b inside {"/", "?", "#", "@"}) || (pct_ok && b == CH_PCT) ||
           (brk && (b inside {":", "[", "]"}));
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h37 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

/* sv/uri_percent_encode_fixup.sv */
// Top level of the URI percent-encoding fixup block: scan/encode state and
// result buffer. Depends on uripe_pkg and uri_percent_encode_fixup_assert.svh.
//
// Usage:
//  Send each string twice on the in_ channel: first as scan bytes, then as
//  encode bytes, with is_final on the last byte of each pass. Scan bytes give
//  no result; encode bytes give zero to four result bytes on the out_ channel.
//  An accepted item updates the parser at once and loads its result bytes
//  into a four-entry buffer; the first byte is valid the cycle after the
//  transaction. The buffer drains one byte a cycle while out_stall is low.
//  An item giving one result or none does not by itself stall the input; an
//  item giving more stalls further items while its bytes drain through the
//  single output port of the buffer. The next item is taken in the cycle the
//  last buffered byte leaves. When out_stall is high the buffered byte holds
//  and, once only that byte remains, in_stall follows out_stall.
//  Reset clears the parser to the start of a string, clears the scan flag
//  and empties the buffer.
`timescale 1ns / 1ps

`include "uri_percent_encode_fixup_assert.svh"

module uri_percent_encode_fixup (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  uripe_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output uripe_pkg::out_t  out_data
);

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SCHEME = 3'd1,
    PH_COLON  = 3'd2,
    PH_SLASH  = 3'd3,
    PH_AUTH   = 3'd4,
    PH_PATH   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    BODY_NONE,
    BODY_RAW,
    BODY_ENC_AUTH,
    BODY_ENC_PATH
  } body_t;

  phase_t      phase_r, phase_nxt;
  logic        brk_r, brk_nxt;
  logic        pb_r, pb_nxt;
  logic [1:0]  hn_r, hn_nxt;
  logic        fresh_r, fresh_nxt;
  logic [7:0]  buf_r [uripe_pkg::MAX_RES];
  logic [7:0]  buf_nxt [uripe_pkg::MAX_RES];
  logic [2:0]  rem_r, rem_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        fin_r, fin_nxt;

  logic        acc, take;
  logic [7:0]  b;
  logic        fin;
  body_t       body;
  logic        pre_one, pre_two;
  logic [2:0]  n_res;

  assign b    = in_data.char_byte;
  assign fin  = in_data.is_final;
  assign take = out_valid && !out_stall;
  assign acc  = in_valid && !in_stall;

  assign in_stall  = (rem_r > 3'd1) || (rem_r == 3'd1 && out_stall);
  assign out_valid = (rem_r != 3'd0);
  assign out_data.out_byte   = buf_r[idx_r];
  assign out_data.run_end    = (rem_r == 3'd1);
  assign out_data.string_end = (rem_r == 3'd1) && fin_r;

  // parser and scan state
  always_comb begin
    phase_nxt = phase_r;
    brk_nxt   = brk_r;
    pb_nxt    = pb_r;
    hn_nxt    = hn_r;
    fresh_nxt = fresh_r;
    body      = BODY_NONE;
    pre_one   = 1'b0;
    pre_two   = 1'b0;
    if (in_data.operation == uripe_pkg::OP_SCAN) begin
      if (fresh_r) begin
        pb_nxt = 1'b0;
        hn_nxt = 2'd0;
      end
      if (hn_nxt != 2'd0) begin
        if (uripe_pkg::is_hex(b)) begin
          hn_nxt = hn_nxt - 2'd1;
        end else begin
          pb_nxt = 1'b1;
          hn_nxt = 2'd0;
        end
      end else if (b == uripe_pkg::CH_PCT) begin
        hn_nxt = 2'd2;
      end
      fresh_nxt = 1'b0;
      if (fin) begin
        if (hn_nxt != 2'd0) begin
          pb_nxt = 1'b1;
        end
        hn_nxt    = 2'd0;
        fresh_nxt = 1'b1;
      end
    end else begin
      fresh_nxt = 1'b1;
      case (phase_r)
        PH_START: begin
          if (uripe_pkg::is_scheme(b)) begin
            body      = BODY_RAW;
            phase_nxt = PH_SCHEME;
          end else if (b == uripe_pkg::CH_SLASH) begin
            brk_nxt   = 1'b0;
            phase_nxt = PH_SLASH;
          end else begin
            brk_nxt   = 1'b0;
            phase_nxt = PH_PATH;
            body      = BODY_ENC_PATH;
          end
        end
        PH_SCHEME: begin
          if (uripe_pkg::is_scheme(b)) begin
            body = BODY_RAW;
          end else if (b == uripe_pkg::CH_COLON) begin
            body      = BODY_RAW;
            brk_nxt   = 1'b1;
            phase_nxt = PH_COLON;
          end else begin
            brk_nxt   = 1'b0;
            phase_nxt = PH_PATH;
            body      = BODY_ENC_PATH;
          end
        end
        PH_COLON: begin
          if (b == uripe_pkg::CH_SLASH) begin
            phase_nxt = PH_SLASH;
          end else begin
            phase_nxt = PH_PATH;
            body      = BODY_ENC_PATH;
          end
        end
        PH_SLASH: begin
          if (b == uripe_pkg::CH_SLASH) begin
            pre_two   = 1'b1;
            brk_nxt   = 1'b0;
            phase_nxt = PH_AUTH;
          end else begin
            pre_one   = 1'b1;
            phase_nxt = PH_PATH;
            body      = BODY_ENC_PATH;
          end
        end
        PH_AUTH: begin
          if (uripe_pkg::is_auth_end(b)) begin
            phase_nxt = PH_PATH;
            body      = BODY_ENC_PATH;
          end else begin
            body = BODY_ENC_AUTH;
          end
        end
        default: begin
          body = BODY_ENC_PATH;
        end
      endcase
    end
  end

  // result bytes of this transaction
  always_comb begin
    logic pass;
    logic post;
    logic [2:0] n;
    for (int i = 0; i < uripe_pkg::MAX_RES; i++) begin
      buf_nxt[i] = buf_r[i];
    end
    n = 3'd0;
    post = (in_data.operation == uripe_pkg::OP_ENCODE) && fin && (phase_nxt == PH_SLASH);
    case (body)
      BODY_ENC_AUTH: pass = uripe_pkg::is_plain(b) || uripe_pkg::auth_extra(b, !pb_r);
      BODY_ENC_PATH: pass = uripe_pkg::is_plain(b) ||
                            uripe_pkg::path_extra(b, brk_nxt, !pb_r);
      default:       pass = 1'b1;
    endcase
    if (pre_one || pre_two) begin
      buf_nxt[n[1:0]] = uripe_pkg::CH_SLASH;
      n = n + 3'd1;
    end
    if (pre_two) begin
      buf_nxt[n[1:0]] = uripe_pkg::CH_SLASH;
      n = n + 3'd1;
    end
    if (body != BODY_NONE) begin
      if (pass) begin
        buf_nxt[n[1:0]] = b;
        n = n + 3'd1;
      end else begin
        buf_nxt[n[1:0]] = uripe_pkg::CH_PCT;
        buf_nxt[n[1:0] + 2'd1] = uripe_pkg::hex_char(b[7:4]);
        buf_nxt[n[1:0] + 2'd2] = uripe_pkg::hex_char(b[3:0]);
        n = n + 3'd3;
      end
    end
    if (post) begin
      buf_nxt[n[1:0]] = uripe_pkg::CH_SLASH;
      n = n + 3'd1;
    end
    n_res = n;
  end

  always_comb begin
    rem_nxt = rem_r;
    idx_nxt = idx_r;
    fin_nxt = fin_r;
    if (acc && n_res != 3'd0) begin
      rem_nxt = n_res;
      idx_nxt = 2'd0;
      fin_nxt = fin;
    end else if (take) begin
      rem_nxt = rem_r - 3'd1;
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      brk_r   <= 1'b0;
      pb_r    <= 1'b0;
      hn_r    <= 2'd0;
      fresh_r <= 1'b1;
      rem_r   <= 3'd0;
      idx_r   <= 2'd0;
      fin_r   <= 1'b0;
    end else begin
      if (acc) begin
        // end of an encode pass returns the parser to the start
        if (in_data.operation == uripe_pkg::OP_ENCODE && fin) begin
          phase_r <= PH_START;
          brk_r   <= 1'b0;
        end else begin
          phase_r <= phase_nxt;
          brk_r   <= brk_nxt;
        end
        pb_r    <= pb_nxt;
        hn_r    <= hn_nxt;
        fresh_r <= fresh_nxt;
      end
      rem_r <= rem_nxt;
      idx_r <= idx_nxt;
      fin_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && n_res != 3'd0) begin
      for (int i = 0; i < uripe_pkg::MAX_RES; i++) begin
        buf_r[i] <= buf_nxt[i];
      end
    end
  end

  `URIPE_ASSERT_NEXT(a_load_shows, acc && n_res != 3'd0, out_valid && rem_r == $past(n_res))
  `URIPE_ASSERT_NEXT(a_run_holds, take && rem_r > 3'd1, out_valid)
  `URIPE_ASSERT_NOW(a_end_is_run, out_valid && out_data.string_end, out_data.run_end)
  `URIPE_ASSERT_NOW(a_hex_owed, 1'b1, hn_r != 2'd3 && rem_r <= 3'd4)

endmodule

/* bench/uri_percent_encode_fixup_tb.sv */
// Testbench for uri_percent_encode_fixup: streams scan and encode passes of URI strings,
// predicts the fixed-up bytes and checks every output transaction in order.
// Depends on uripe_pkg and the block's RTL.
`timescale 1ns / 1ps

class uri_fixup_tracker;
  typedef enum logic [2:0] {
    PH_START, PH_SCHEME, PH_COLON, PH_SLASH, PH_AUTH, PH_PATH
  } phase_t;

  uripe_pkg::out_t  due_bytes[$];
  int               faults;
  local logic [1:0] hex_owed;
  local logic       pct_broken;
  local logic       scan_new;
  local phase_t     phase;
  local logic       brk_ok;
  local uripe_pkg::out_t burst[$];

  function new();
    hex_owed   = 2'd0;
    pct_broken = 1'b0;
    scan_new   = 1'b1;
    phase      = PH_START;
    brk_ok     = 1'b0;
    faults     = 0;
  endfunction

  local function bit alnum(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  local function bit hexdig(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
  endfunction

  local function bit has_char(string chars, logic [7:0] b);
    for (int i = 0; i < chars.len(); i++) begin
      if (chars[i] == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  local function bit scheme_char(logic [7:0] b);
    return alnum(b) || has_char("+-.", b);
  endfunction

  local function logic [7:0] nibble_char(logic [3:0] nib);
    return (nib < 4'd10) ? 8'("0") + 8'(nib) : 8'("A") + 8'(nib) - 8'd10;
  endfunction

  local function void put(logic [7:0] b);
    uripe_pkg::out_t r;
    r.out_byte   = b;
    r.run_end    = 1'b0;
    r.string_end = 1'b0;
    burst.insert(burst.size(), r);
  endfunction

  // with every extras set '%' passes unencoded until the scan has flagged a bad escape
  local function void put_coded(logic [7:0] b, string extras);
    if (alnum(b) || has_char("-._~!$&'()*+,;=", b) || has_char(extras, b) ||
        (!pct_broken && b == uripe_pkg::CH_PCT)) begin
      put(b);
    end else begin
      put(uripe_pkg::CH_PCT);
      put(nibble_char(b[7:4]));
      put(nibble_char(b[3:0]));
    end
  endfunction

  local function string path_extras();
    return brk_ok ? ":/?#[]@" : "/?#@";
  endfunction

  function void take_byte(uripe_pkg::in_t it);
    logic [7:0]      b;
    uripe_pkg::out_t last;
    b = it.char_byte;
    burst.delete();
    if (it.operation == uripe_pkg::OP_SCAN) begin
      if (scan_new) begin
        pct_broken = 1'b0;
        hex_owed   = 2'd0;
        scan_new   = 1'b0;
      end
      if (hex_owed != 2'd0) begin
        if (hexdig(b)) begin
          hex_owed = hex_owed - 2'd1;
        end else begin
          pct_broken = 1'b1;
          hex_owed   = 2'd0;
        end
      end else if (b == uripe_pkg::CH_PCT) begin
        hex_owed = 2'd2;
      end
      if (it.is_final) begin
        if (hex_owed != 2'd0) pct_broken = 1'b1;
        hex_owed = 2'd0;
        scan_new = 1'b1;
      end
      return;
    end
    scan_new = 1'b1;
    case (phase)
      PH_START: begin
        if (scheme_char(b)) begin
          put(b);
          phase = PH_SCHEME;
        end else if (b == uripe_pkg::CH_SLASH) begin
          brk_ok = 1'b0;
          phase  = PH_SLASH;
        end else begin
          brk_ok = 1'b0;
          phase  = PH_PATH;
          put_coded(b, path_extras());
        end
      end
      PH_SCHEME: begin
        if (scheme_char(b)) begin
          put(b);
        end else if (b == uripe_pkg::CH_COLON) begin
          put(b);
          brk_ok = 1'b1;
          phase  = PH_COLON;
        end else begin
          brk_ok = 1'b0;
          phase  = PH_PATH;
          put_coded(b, path_extras());
        end
      end
      PH_COLON: begin
        if (b == uripe_pkg::CH_SLASH) begin
          phase = PH_SLASH;
        end else begin
          phase = PH_PATH;
          put_coded(b, path_extras());
        end
      end
      PH_SLASH: begin
        put(uripe_pkg::CH_SLASH);
        if (b == uripe_pkg::CH_SLASH) begin
          put(uripe_pkg::CH_SLASH);
          brk_ok = 1'b0;
          phase  = PH_AUTH;
        end else begin
          phase = PH_PATH;
          put_coded(b, path_extras());
        end
      end
      PH_AUTH: begin
        if (has_char("/?#", b)) begin
          phase = PH_PATH;
          put_coded(b, path_extras());
        end else begin
          put_coded(b, ":[]@");
        end
      end
      default: put_coded(b, path_extras());
    endcase
    if (it.is_final) begin
      if (phase == PH_SLASH) put(uripe_pkg::CH_SLASH);
      phase  = PH_START;
      brk_ok = 1'b0;
    end
    if (burst.size() > 0) begin
      last            = burst[burst.size() - 1];
      last.run_end    = 1'b1;
      last.string_end = it.is_final;
      burst[burst.size() - 1] = last;
    end
    foreach (burst[i]) due_bytes.insert(due_bytes.size(), burst[i]);
  endfunction

  local function void note_fault(string msg);
    faults++;
    if (faults <= 10) $display("%s", msg);
  endfunction

  function void match_output(uripe_pkg::out_t got);
    uripe_pkg::out_t want;
    if (due_bytes.size() == 0) begin
      note_fault($sformatf("unexpected byte %02h run_end %0b string_end %0b",
                           got.out_byte, got.run_end, got.string_end));
      return;
    end
    want = due_bytes.pop_front();
    if (got.out_byte !== want.out_byte || got.run_end !== want.run_end ||
        got.string_end !== want.string_end) begin
      note_fault($sformatf({"mismatch: byte %02h/%02h run_end %0b/%0b ",
                            "string_end %0b/%0b (expected/actual)"},
                           want.out_byte, got.out_byte, want.run_end, got.run_end,
                           want.string_end, got.string_end));
    end
  endfunction
endclass

module uri_percent_encode_fixup_tb;
  localparam string ALNUM_CH  = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
  localparam string HEX_CH    = "0123456789ABCDEFabcdef";
  localparam string SCHEME_CH = "abhtpsz09+-.";
  localparam string AUTH_CH   = "abcxyz019.-_~:@[]!$";
  localparam string PATH_CH   = "abcXYZ09/?#@:[]~!$&'()*+,;=-._ <>{}|^";

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  uripe_pkg::in_t  in_data;
  logic            out_valid;
  logic            out_stall;
  uripe_pkg::out_t out_data;

  uri_fixup_tracker tracker;
  bit               send_calm;
  bit               recv_calm;
  int               items_sent;
  logic [7:0]       text[$];

  uri_percent_encode_fixup dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int draw_wait(bit calm);
    return calm ? 0 : int'($urandom_range(0, 16));
  endfunction

  function automatic logic [7:0] pick(string pool);
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  function automatic void add_byte(logic [7:0] c);
    text.insert(text.size(), c);
  endfunction

  function automatic void load(string s);
    text.delete();
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_uri_char(string pool);
    case ($urandom_range(0, 9))
      0: begin
        add_byte(uripe_pkg::CH_PCT);
        add_byte(pick(HEX_CH));
        add_byte(pick(HEX_CH));
      end
      1: begin
        add_byte(uripe_pkg::CH_PCT);
        add_byte(pick(ALNUM_CH));
      end
      2: add_byte(8'($urandom_range(0, 255)));
      3: add_byte(uripe_pkg::CH_SLASH);
      default: add_byte(pick(pool));
    endcase
  endfunction

  function automatic void build_text();
    int len;
    text.delete();
    if ($urandom_range(0, 9) >= 8) begin
      len = $urandom_range(1, 8);
      repeat (len) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 9) < 7) begin
      repeat ($urandom_range(1, 5)) add_byte(pick(SCHEME_CH));
      if ($urandom_range(0, 6) != 0) add_byte(uripe_pkg::CH_COLON);
    end
    if ($urandom_range(0, 1) == 1) begin
      add_byte(uripe_pkg::CH_SLASH);
      add_byte(uripe_pkg::CH_SLASH);
      repeat ($urandom_range(0, 6)) add_uri_char(AUTH_CH);
    end
    repeat ($urandom_range(0, 8)) add_uri_char(PATH_CH);
    if (text.size() == 0) add_byte(uripe_pkg::CH_SLASH);
  endfunction

  task automatic send_item(input logic op, input logic [7:0] b, input logic fin);
    uripe_pkg::in_t item;
    int             gap;
    item.operation = op;
    item.char_byte = b;
    item.is_final  = fin;
    gap = draw_wait(send_calm);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    tracker.take_byte(item);
    items_sent++;
  endtask

  // stray_at: position of an interleaved scan byte, -1 for none
  task automatic send_text(input logic op, input bit close, input int stray_at);
    for (int i = 0; i < text.size(); i++) begin
      if (i == stray_at) begin
        send_item(uripe_pkg::OP_SCAN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      send_item(op, text[i], close && (i == text.size() - 1));
    end
  endtask

  task automatic hold_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.due_bytes.size() != 0) @(posedge clk);
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        tracker.match_output(out_data);
        if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
        stall_left = draw_wait(recv_calm);
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int n;
    int kind;
    tracker    = new();
    items_sent = 0;
    send_calm  = 1'b0;
    recv_calm  = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // truncated escape, then a held slash closing the string
    load("%4");
    send_text(uripe_pkg::OP_SCAN, 1'b1, -1);
    load("x:/");
    send_text(uripe_pkg::OP_ENCODE, 1'b1, -1);
    // encode before scan end, scan byte inside an encode pass, high byte
    send_item(uripe_pkg::OP_SCAN, uripe_pkg::CH_PCT, 1'b0);
    send_item(uripe_pkg::OP_ENCODE, uripe_pkg::CH_PCT, 1'b1);
    send_item(uripe_pkg::OP_ENCODE, uripe_pkg::CH_SLASH, 1'b0);
    send_item(uripe_pkg::OP_SCAN, "q", 1'b1);
    send_item(uripe_pkg::OP_ENCODE, 8'h80, 1'b1);
    // bad escape: '%' gets encoded in the authority
    load("%z");
    send_text(uripe_pkg::OP_SCAN, 1'b1, -1);
    load("//%:");
    add_byte(8'hFF);
    send_text(uripe_pkg::OP_ENCODE, 1'b1, -1);
    // good escapes, bracketed path after scheme colon
    load("%Af");
    send_text(uripe_pkg::OP_SCAN, 1'b1, -1);
    load("h:[");
    add_byte(8'h00);
    add_byte(uripe_pkg::CH_PCT);
    send_text(uripe_pkg::OP_ENCODE, 1'b1, -1);
    hold_for_drain();

    n = 0;
    while (items_sent < 310) begin
      n++;
      if (n % 6 == 0) hold_for_drain();
      if ($urandom_range(0, 3) == 0) send_calm = !send_calm;
      build_text();
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        send_text(uripe_pkg::OP_SCAN, 1'b1, -1);
      end else if (kind == 7) begin
        send_text(uripe_pkg::OP_SCAN, 1'b0, -1);
      end
      send_text(uripe_pkg::OP_ENCODE, $urandom_range(0, 11) != 0,
                ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, text.size() - 1)) : -1);
    end
    in_valid <= 1'b0;

    while (tracker.due_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.faults == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
